// ===== design/hsp_pkg.sv =====
// Package for the HTTP/2 SETTINGS payload parser.
// Holds the entry geometry, the setting identifiers, range limits and reset values.
// No dependencies.
`default_nettype none

package hsp_pkg;

  // Entry geometry: 16-bit identifier followed by a 32-bit value
  localparam int unsigned EntryBytes = 6;
  localparam int unsigned PosW       = 3;
  localparam int unsigned ShiftW     = 40;

  localparam logic [PosW-1:0] PosLast = PosW'(EntryBytes - 1);
  localparam logic [PosW-1:0] PosZero = '0;

  // Setting identifiers
  typedef enum logic [15:0] {
    IdHeaderTableSize    = 16'd1,
    IdEnablePush         = 16'd2,
    IdMaxConcurrentStrms = 16'd3,
    IdInitialWindowSize  = 16'd4,
    IdMaxFrameSize       = 16'd5
  } setting_id_e;

  // Range limits
  localparam logic [31:0] FrameSizeMin = 32'd16384;
  localparam logic [31:0] FrameSizeMax = 32'd16777215;

  // Reset values of the stored peer settings
  localparam logic [31:0] TableSizeReset  = 32'd4096;
  localparam logic        PushReset       = 1'b1;
  localparam logic [31:0] StreamsReset    = 32'hffff_ffff;
  localparam logic [30:0] WindowReset     = 31'd65535;
  localparam logic [23:0] FrameSizeReset  = 24'd16384;

  // Stored peer settings
  typedef struct packed {
    logic [31:0] table_size;
    logic        push;
    logic [31:0] streams;
    logic [30:0] window;
    logic [23:0] frame_size;
  } settings_t;

  localparam settings_t SettingsReset = '{
    table_size: TableSizeReset,
    push:       PushReset,
    streams:    StreamsReset,
    window:     WindowReset,
    frame_size: FrameSizeReset
  };

endpackage

`default_nettype wire

// ===== design/http2_settings_payload_parser_core.sv =====
// HTTP/2 SETTINGS payload parser, top level.
// A result is registered and appears in the cycle after the final payload byte is transferred.
// Throughput: one byte per cycle; the input stalls only while a result waits unread.
// Reset: peer settings return to 4096 / 1 / 0xffffffff / 65535 / 16384, entry
// position, partial entry and the failed mark clear, and no result is pending.
// Depends on hsp_pkg.
`default_nettype none

module http2_settings_payload_parser_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Payload byte channel
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  input  wire logic        last_i,
  // Result channel
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             status_o,
  output logic [31:0]      tbl_size_o,
  output logic             push_en_o,
  output logic [31:0]      stream_limit_o,
  output logic [30:0]      win_size_o,
  output logic [23:0]      frame_limit_o
);

  // Parser state
  hsp_pkg::settings_t                settings_q, settings_d;
  logic [hsp_pkg::PosW-1:0]          pos_q, pos_d;
  logic [hsp_pkg::ShiftW-1:0]        shift_q, shift_d;
  logic                              failed_q, failed_d;

  // Result register
  logic                              out_valid_q, out_valid_d;
  logic                              status_q, status_d;
  hsp_pkg::settings_t                result_q, result_d;

  logic        in_fire;
  logic        entry_done;
  logic [15:0] ident;
  logic [31:0] value;
  logic        bad_value;
  logic        failed_entry;
  logic [hsp_pkg::PosW-1:0] pos_next;

  // Accept a byte whenever the result slot is free or being drained
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // Split the completed entry
  assign entry_done = (pos_q == hsp_pkg::PosLast);
  assign ident      = shift_q[39:24];
  assign value      = {shift_q[23:0], data_byte_i};

  // Range check of the completed entry
  always_comb begin
    bad_value = 1'b0;
    unique case (ident)
      hsp_pkg::IdEnablePush:        bad_value = (value > 32'd1);
      hsp_pkg::IdInitialWindowSize: bad_value = value[31];
      hsp_pkg::IdMaxFrameSize:      bad_value = (value < hsp_pkg::FrameSizeMin) ||
                                                (value > hsp_pkg::FrameSizeMax);
      default:                      bad_value = 1'b0;
    endcase
  end

  assign failed_entry = failed_q || (entry_done && bad_value);
  assign pos_next     = entry_done ? hsp_pkg::PosZero : pos_q + 1'b1;

  // Apply entries, advance the position, and build the result on the last byte
  always_comb begin
    settings_d  = settings_q;
    pos_d       = pos_q;
    shift_d     = shift_q;
    failed_d    = failed_q;
    out_valid_d = out_valid_q && !out_ready_i;
    status_d    = status_q;
    result_d    = result_q;

    if (in_fire) begin
      if (entry_done) begin
        if (!failed_q && !bad_value) begin
          unique case (ident)
            hsp_pkg::IdHeaderTableSize:    settings_d.table_size = value;
            hsp_pkg::IdEnablePush:         settings_d.push       = value[0];
            hsp_pkg::IdMaxConcurrentStrms: settings_d.streams    = value;
            hsp_pkg::IdInitialWindowSize:  settings_d.window     = value[30:0];
            hsp_pkg::IdMaxFrameSize:       settings_d.frame_size = value[23:0];
            default:                       settings_d            = settings_q;
          endcase
        end
        shift_d = '0;
      end else begin
        shift_d = {shift_q[hsp_pkg::ShiftW-9:0], data_byte_i};
      end
      pos_d    = pos_next;
      failed_d = failed_entry;

      if (last_i) begin
        out_valid_d = 1'b1;
        status_d    = failed_entry || (pos_next != hsp_pkg::PosZero);
        result_d    = settings_d;
        pos_d       = hsp_pkg::PosZero;
        shift_d     = '0;
        failed_d    = 1'b0;
      end
    end
  end

  // Control and settings registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settings_q  <= hsp_pkg::SettingsReset;
      pos_q       <= hsp_pkg::PosZero;
      shift_q     <= '0;
      failed_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      settings_q  <= settings_d;
      pos_q       <= pos_d;
      shift_q     <= shift_d;
      failed_q    <= failed_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Result payload, no reset needed
  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    result_q <= result_d;
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign tbl_size_o     = result_q.table_size;
  assign push_en_o      = result_q.push;
  assign stream_limit_o = result_q.streams;
  assign win_size_o     = result_q.window;
  assign frame_limit_o  = result_q.frame_size;

  // Checks
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= hsp_pkg::PosLast)
    else $error("entry position out of range");

  a_frame_size_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (frame_limit_o >= hsp_pkg::FrameSizeMin[23:0]))
    else $error("reported max frame size below minimum");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && last_i) |=> (out_valid_o && pos_q == hsp_pkg::PosZero && !failed_q &&
                             shift_q == '0))
    else $error("frame end did not produce a result or clear parser state");

  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_q && !(in_fire && last_i)) |=> !out_valid_o)
    else $error("result appeared without a final byte");

endmodule

`default_nettype wire

// ===== verif/tb_http2_settings_payload_parser_core.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the HTTP/2 SETTINGS parser core; depends on hsp_pkg.
// Feeds directed and random payload frames over valid/ready; directed results are
// checked against typed rows, random ones against a cycle-free update-rule model.

module tb_http2_settings_payload_parser_core;

  localparam logic [31:0] WindowMax  = 32'h7fff_ffff;
  localparam int          StallLimit = 5000;
  localparam int          ByteTarget = 2000;
  localparam int          DirLen     = 25;

  // Directed frames, one row per byte: bit 8 marks the last byte of a frame
  localparam logic [9*DirLen-1:0] DirTable = {
    // lone byte: partial entry, rejected
    9'h1ff,
    // window at its maximum, frame size at its maximum
    9'h000, 9'h004, 9'h07f, 9'h0ff, 9'h0ff, 9'h0ff,
    9'h000, 9'h005, 9'h000, 9'h0ff, 9'h0ff, 9'h1ff,
    // frame size one below its minimum: rejected
    9'h000, 9'h005, 9'h000, 9'h000, 9'h03f, 9'h1ff,
    // unknown identifier with an all-ones value: ignored
    9'h0ff, 9'h0ff, 9'h0ff, 9'h0ff, 9'h0ff, 9'h1ff
  };

  typedef struct packed {
    logic               status;
    hsp_pkg::settings_t cfg;
  } result_t;

  logic        clk_i;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [7:0]  data_byte_i = 8'h00;
  logic        last_i      = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        status_o;
  logic [31:0] tbl_size_o;
  logic        push_en_o;
  logic [31:0] stream_limit_o;
  logic [30:0] win_size_o;
  logic [23:0] frame_limit_o;

  // Typed expectation that travels with the current byte
  logic    row_typed  = 1'b0;
  result_t row_expect = '0;

  // Model state
  hsp_pkg::settings_t peer      = hsp_pkg::SettingsReset;
  logic [2:0]         ent_pos   = hsp_pkg::PosZero;
  logic [39:0]        ent_shift = '0;
  logic               frame_bad = 1'b0;

  result_t pending_results [$];
  result_t frame_expect [4];
  int      errors       = 0;
  int      results_seen = 0;
  int      bytes_sent   = 0;
  int      burst_left   = 0;

  http2_settings_payload_parser_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .last_i         (last_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .tbl_size_o     (tbl_size_o),
    .push_en_o      (push_en_o),
    .stream_limit_o (stream_limit_o),
    .win_size_o     (win_size_o),
    .frame_limit_o  (frame_limit_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Advance the settings model by one payload byte
  task automatic settings_step(input logic [7:0] b, input logic l,
                               output logic has_result, output result_t res);
    logic [15:0] ident;
    logic [31:0] value;
    logic        ok;
    has_result = 1'b0;
    res        = '0;
    if (ent_pos >= hsp_pkg::PosLast) begin
      ident = ent_shift[39:24];
      value = {ent_shift[23:0], b};
      ok    = 1'b1;
      if (!frame_bad) begin
        case (ident)
          hsp_pkg::IdHeaderTableSize:    peer.table_size = value;
          hsp_pkg::IdEnablePush: begin
            if (value > 32'd1) ok = 1'b0;
            else peer.push = value[0];
          end
          hsp_pkg::IdMaxConcurrentStrms: peer.streams = value;
          hsp_pkg::IdInitialWindowSize: begin
            if (value > WindowMax) ok = 1'b0;
            else peer.window = value[30:0];
          end
          hsp_pkg::IdMaxFrameSize: begin
            if (value < hsp_pkg::FrameSizeMin || value > hsp_pkg::FrameSizeMax) ok = 1'b0;
            else peer.frame_size = value[23:0];
          end
          default: ;
        endcase
        if (!ok) frame_bad = 1'b1;
      end
      ent_pos   = hsp_pkg::PosZero;
      ent_shift = '0;
    end else begin
      ent_shift = {ent_shift[31:0], b};
      ent_pos   = ent_pos + 3'd1;
    end
    // Close the frame on its last byte
    if (l) begin
      if (ent_pos != hsp_pkg::PosZero) frame_bad = 1'b1;
      has_result = 1'b1;
      res        = '{status: frame_bad, cfg: peer};
      ent_pos    = hsp_pkg::PosZero;
      ent_shift  = '0;
      frame_bad  = 1'b0;
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] seen);
    if (want !== seen) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, seen);
      errors++;
    end
  endtask

  // Compare finished results and predict on every accepted byte
  always @(posedge clk_i) begin : scoreboard
    result_t want;
    result_t predicted;
    logic    has_result;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          $display("%0t: result with none pending, status %0b", $time, status_o);
          errors++;
        end else begin
          want = pending_results.pop_front();
          check_field("status", 32'(want.status), 32'(status_o));
          check_field("tbl_size", want.cfg.table_size, tbl_size_o);
          check_field("push_en", 32'(want.cfg.push), 32'(push_en_o));
          check_field("stream_limit", want.cfg.streams, stream_limit_o);
          check_field("win_size", 32'(want.cfg.window), 32'(win_size_o));
          check_field("frame_limit", 32'(want.cfg.frame_size), 32'(frame_limit_o));
        end
      end
      if (in_valid_i && in_ready_o) begin
        settings_step(data_byte_i, last_i, has_result, predicted);
        if (has_result) pending_results.push_back(row_typed ? row_expect : predicted);
      end
    end
  end

  // End the run if nothing moves on either channel for too long
  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < StallLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle = 0;
      else idle++;
    end
    $display("FAIL");
    $finish;
  end

  // Receiver: switch among randomly chosen stall patterns, with one long hold-off
  initial begin : receiver
    int  cnt;
    int  mode;
    bit  hold_done;
    cnt       = 0;
    mode      = 0;
    hold_done = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!hold_done && results_seen >= 40) begin
        hold_done = 1'b1;
        out_ready_i <= 1'b0;
        repeat (400) @(negedge clk_i);
      end
      if (cnt % 64 == 0) mode = $urandom_range(0, 3);
      cnt++;
      case (mode)
        0:       out_ready_i <= 1'b1;
        1:       out_ready_i <= 1'($urandom_range(0, 1));
        2:       out_ready_i <= ($urandom_range(0, 3) == 0);
        default: out_ready_i <= (cnt[1:0] != 2'b11);
      endcase
    end
  end

  // Offer one byte in bursts with gaps; hold it until the transfer
  task automatic send_byte(input logic [7:0] b, input logic l, input logic typed,
                           input result_t want);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(1, 40);
      gap        = $urandom_range(1, 6);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    burst_left--;
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    last_i      <= l;
    row_typed   <= typed;
    row_expect  <= want;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    bytes_sent++;
  endtask

  function automatic logic [15:0] pick_id();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) begin
      return 16'($urandom_range(hsp_pkg::IdHeaderTableSize, hsp_pkg::IdMaxFrameSize));
    end
    if (r == 7) return 16'h0000;
    return 16'($urandom_range(0, 16'hffff));
  endfunction

  // Mostly legal values, with boundaries and out-of-range ones mixed in
  function automatic logic [31:0] pick_value(input logic [15:0] ident);
    int          r;
    logic [31:0] v;
    r = $urandom_range(0, 9);
    v = $urandom;
    case (ident)
      hsp_pkg::IdEnablePush: begin
        if (r < 8) v = 32'($urandom_range(0, 1));
        else if (r == 8) v = 32'd2;
      end
      hsp_pkg::IdInitialWindowSize: begin
        if (r < 2) v = WindowMax;
        else if (r == 2) v = WindowMax + 32'd1;
        else if (r < 9) v[31] = 1'b0;
      end
      hsp_pkg::IdMaxFrameSize: begin
        if (r < 2) v = hsp_pkg::FrameSizeMin;
        else if (r < 4) v = hsp_pkg::FrameSizeMax;
        else if (r == 4) v = hsp_pkg::FrameSizeMin - 32'd1;
        else if (r == 5) v = hsp_pkg::FrameSizeMax + 32'd1;
        else if (r < 9) v = $urandom_range(hsp_pkg::FrameSizeMin, hsp_pkg::FrameSizeMax);
      end
      default: begin
        if (r < 2) v = 32'h0000_0000;
        else if (r < 4) v = 32'hffff_ffff;
      end
    endcase
    return v;
  endfunction

  initial begin : stimulus
    hsp_pkg::settings_t tuned;
    logic [8:0]         row;
    logic [15:0]        ident;
    logic [31:0]        value;
    logic [47:0]        entry;
    logic [7:0]         frame_q [$];
    int                 f;
    int                 frames;
    int                 kind;
    int                 n_entries;
    int                 extra;

    // Typed expectations of the directed frames
    tuned            = hsp_pkg::SettingsReset;
    tuned.window     = WindowMax[30:0];
    tuned.frame_size = hsp_pkg::FrameSizeMax[23:0];
    frame_expect[0]  = '{status: 1'b1, cfg: hsp_pkg::SettingsReset};
    frame_expect[1]  = '{status: 1'b0, cfg: tuned};
    frame_expect[2]  = '{status: 1'b1, cfg: tuned};
    frame_expect[3]  = '{status: 1'b0, cfg: tuned};

    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Walk the directed table
    f = 0;
    for (int i = 0; i < DirLen; i++) begin
      row = DirTable[9*(DirLen-1-i) +: 9];
      send_byte(row[7:0], row[8], row[8], frame_expect[f]);
      if (row[8]) f++;
    end

    // Random frames: mostly well formed, some with a partial tail, some noise
    frames = 0;
    while (bytes_sent < ByteTarget) begin
      frame_q.delete();
      kind      = $urandom_range(0, 9);
      n_entries = 0;
      extra     = 0;
      if (kind < 9) begin
        n_entries = ($urandom_range(0, 15) == 0) ? $urandom_range(5, 10)
                                                 : $urandom_range(1, 4);
        if (kind >= 7) extra = $urandom_range(1, 5);
      end else begin
        extra = $urandom_range(1, 18);
      end
      for (int e = 0; e < n_entries; e++) begin
        ident = pick_id();
        value = pick_value(ident);
        entry = {ident, value};
        for (int k = 0; k < 6; k++) frame_q.push_back(entry[47-8*k -: 8]);
      end
      for (int k = 0; k < extra; k++) frame_q.push_back(8'($urandom_range(0, 255)));
      foreach (frame_q[k]) send_byte(frame_q[k], k == frame_q.size() - 1, 1'b0, '0);
      frames++;

      // Once, let the result channel drain completely before going on
      if (frames == 60) begin
        in_valid_i <= 1'b0;
        @(negedge clk_i);
        while (pending_results.size() != 0) @(negedge clk_i);
      end
    end

    // Drain and settle
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (50) @(negedge clk_i);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
